### rtl/bed_pkg.sv
// Shared types, codes and character constants for the backslash escape decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bed_pkg;

  // Parser modes, one-hot.
  typedef enum logic [10:0] {
    M_IDLE     = 11'b000_0000_0001,
    M_ESC      = 11'b000_0000_0010,
    M_OCT1     = 11'b000_0000_0100,
    M_OCT2     = 11'b000_0000_1000,
    M_HEXSTART = 11'b000_0001_0000,
    M_HEX1     = 11'b000_0010_0000,
    M_HEX1BAD  = 11'b000_0100_0000,
    M_GRP      = 11'b000_1000_0000,
    M_GRP1     = 11'b001_0000_0000,
    M_GRP1BAD  = 11'b010_0000_0000,
    M_ERR      = 11'b100_0000_0000
  } bed_mode_e;

  // Status codes of the closing item.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INC_ESC   = 3'd1;
  localparam logic [2:0] ST_INC_OCT   = 3'd2;
  localparam logic [2:0] ST_BAD_OCT   = 3'd3;
  localparam logic [2:0] ST_OCT_LARGE = 3'd4;
  localparam logic [2:0] ST_INC_HEX   = 3'd5;
  localparam logic [2:0] ST_BAD_HEX   = 3'd6;
  localparam logic [2:0] ST_INC_GROUP = 3'd7;

  // Item kinds.
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Characters the parser looks for.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_THREE  = 8'h33;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_X   = 8'h78;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // One result item.
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [2:0] status;
    logic       eos;
  } bed_item_t;

  // Up to two results from one input byte; slot 1 is used only if slot 0 is.
  typedef struct packed {
    logic      valid0;
    logic      valid1;
    bed_item_t item0;
    bed_item_t item1;
  } bed_push_t;

  // Value of a hex digit in bits 3:0; bit 4 set means not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) v = {1'b0, b[3:0]};
    else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      v = {1'b0, 4'(b[3:0] + 4'd9)};
    end
    return v;
  endfunction

endpackage

### rtl/bed_core.sv
// Parser state and per-byte decode logic of the backslash escape decoder.
// Depends on bed_pkg; produces up to two result items per accepted byte.
`timescale 1ns / 1ps

module bed_core import bed_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_fire_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output bed_push_t  push_o
);

  bed_mode_e  mode_q, mode_d;
  logic [7:0] acc_q, acc_d;
  logic       bad_q, bad_d;
  logic       large_q, large_d;

  logic       data_v;
  logic [7:0] data_b;
  logic [2:0] status;
  logic [4:0] hv;
  logic       is_oct;
  logic       bad_now;
  bed_item_t  data_item;
  bed_item_t  stat_item;

  always_comb begin
    mode_d  = mode_q;
    acc_d   = acc_q;
    bad_d   = bad_q;
    large_d = large_q;
    data_v  = 1'b0;
    data_b  = 8'h00;
    hv      = hex_value(in_byte_i);
    is_oct  = (in_byte_i >= CH_ZERO) && (in_byte_i <= CH_SEVEN);
    bad_now = bad_q | ~is_oct;

    case (mode_q)
      M_ESC: begin
        mode_d = M_IDLE;
        if (in_byte_i == CH_LC_N) begin
          data_v = 1'b1;
          data_b = CH_NL;
        end else if (in_byte_i == CH_LC_T) begin
          data_v = 1'b1;
          data_b = CH_TAB;
        end else if (in_byte_i == CH_LC_R) begin
          data_v = 1'b1;
          data_b = CH_CR;
        end else if (in_byte_i == CH_LC_X) begin
          mode_d = M_HEXSTART;
        end else if (in_byte_i >= CH_ZERO && in_byte_i <= CH_NINE) begin
          // Digits 8 and 9 open an octal escape that is flagged bad.
          bad_d   = ~is_oct;
          large_d = in_byte_i > CH_THREE;
          acc_d   = {5'd0, in_byte_i[2:0]};
          mode_d  = M_OCT1;
        end else begin
          data_v = 1'b1;
          data_b = in_byte_i;
        end
      end
      M_OCT1: begin
        bad_d  = bad_now;
        acc_d  = {acc_q[4:0], in_byte_i[2:0]};
        mode_d = M_OCT2;
      end
      M_OCT2: begin
        bad_d = bad_now;
        if (bad_now) begin
          mode_d = M_ERR;
          acc_d  = {5'd0, ST_BAD_OCT};
        end else if (large_q) begin
          mode_d = M_ERR;
          acc_d  = {5'd0, ST_OCT_LARGE};
        end else begin
          data_v = 1'b1;
          data_b = {acc_q[4:0], in_byte_i[2:0]};
          mode_d = M_IDLE;
        end
      end
      M_HEXSTART: begin
        if (in_byte_i == CH_LBRACE) begin
          mode_d = M_GRP;
        end else begin
          acc_d  = {4'd0, hv[3:0]};
          mode_d = hv[4] ? M_HEX1BAD : M_HEX1;
        end
      end
      M_GRP: begin
        if (in_byte_i == CH_RBRACE) begin
          mode_d = M_IDLE;
        end else begin
          acc_d  = {4'd0, hv[3:0]};
          mode_d = hv[4] ? M_GRP1BAD : M_GRP1;
        end
      end
      M_HEX1, M_HEX1BAD, M_GRP1, M_GRP1BAD: begin
        // A bad first digit is only reported once its pair is complete.
        if (mode_q == M_HEX1BAD || mode_q == M_GRP1BAD || hv[4]) begin
          mode_d = M_ERR;
          acc_d  = {5'd0, ST_BAD_HEX};
        end else begin
          data_v = 1'b1;
          data_b = {acc_q[3:0], hv[3:0]};
          mode_d = (mode_q == M_GRP1) ? M_GRP : M_IDLE;
        end
      end
      M_ERR: begin
        mode_d = M_ERR;
      end
      default: begin
        if (in_byte_i == CH_BSLASH) begin
          mode_d = M_ESC;
        end else begin
          data_v = 1'b1;
          data_b = in_byte_i;
          mode_d = M_IDLE;
        end
      end
    endcase

    case (mode_d)
      M_ESC:                                             status = ST_INC_ESC;
      M_OCT1, M_OCT2:                                    status = ST_INC_OCT;
      M_HEXSTART, M_HEX1, M_HEX1BAD, M_GRP1, M_GRP1BAD:  status = ST_INC_HEX;
      M_GRP:                                             status = ST_INC_GROUP;
      M_ERR:                                             status = acc_d[2:0];
      default:                                           status = ST_OK;
    endcase

    if (in_last_i) begin
      mode_d  = M_IDLE;
      acc_d   = 8'h00;
      bad_d   = 1'b0;
      large_d = 1'b0;
    end
  end

  always_comb begin
    data_item        = '{kind: KIND_DATA, data: data_b, status: ST_OK, eos: 1'b0};
    stat_item        = '{kind: KIND_STATUS, data: 8'h00, status: status, eos: 1'b1};
    push_o.valid0    = in_fire_i & (data_v | in_last_i);
    push_o.valid1    = in_fire_i & data_v & in_last_i;
    push_o.item0     = data_v ? data_item : stat_item;
    push_o.item1     = stat_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      acc_q   <= 8'h00;
      bad_q   <= 1'b0;
      large_q <= 1'b0;
    end else if (in_fire_i) begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      bad_q   <= bad_d;
      large_q <= large_d;
    end
  end

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && in_last_i |=> mode_q == M_IDLE && acc_q == 8'h00)
    else $error("parser did not return to idle after the last byte");

  a_second_slot_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid1 |-> push_o.valid0 && push_o.item1.kind == KIND_STATUS
                      && push_o.item0.kind == KIND_DATA)
    else $error("second result slot used out of order");

  a_error_code_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == M_ERR |-> acc_q[2:0] == ST_BAD_OCT || acc_q[2:0] == ST_OCT_LARGE
                        || acc_q[2:0] == ST_BAD_HEX)
    else $error("error mode without a stored error code");

endmodule

### rtl/bed_outq.sv
// Result queue of the backslash escape decoder: takes up to two items a cycle,
// hands out one a cycle while the reader is ready. Depends on bed_pkg.
`timescale 1ns / 1ps

module bed_outq import bed_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bed_push_t push_i,
  output logic      space_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output bed_item_t out_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

  bed_item_t       mem_q [Depth];
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [PtrW-1:0] tail_p1;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;
  logic [1:0]      push_n;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == LastIdx) ? '0 : PtrW'(p + 1'b1);
  endfunction

  assign pop         = out_valid_o & out_ready_i;
  assign push_n      = {1'b0, push_i.valid0} + {1'b0, push_i.valid1};
  assign tail_p1     = wrap_inc(tail_q);
  assign out_valid_o = count_q != '0;
  assign out_item_o  = mem_q[head_q];
  // Room for a data byte and a closing status item from the same request.
  assign space_o     = count_q <= CntW'(Depth - 2);

  always_comb begin
    head_d  = pop ? wrap_inc(head_q) : head_q;
    tail_d  = tail_q;
    if (push_i.valid1) tail_d = wrap_inc(tail_p1);
    else if (push_i.valid0) tail_d = tail_p1;
    count_d = CntW'(count_q + CntW'(push_n) - CntW'(pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid0) mem_q[tail_q] <= push_i.item0;
    if (push_i.valid1) mem_q[tail_p1] <= push_i.item1;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue overflow");

  a_push_needs_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid0 |-> $past(1'b1) && count_q <= CntW'(Depth - 2) + CntW'(!push_i.valid1))
    else $error("push into a full result queue");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_i.valid0 && pop |=> count_q == $past(count_q) - 1'b1)
    else $error("queue count out of step with pops");

endmodule

### rtl/backslash_escape_decoder.sv
// Backslash escape decoder: takes one escaped-string byte per request and
// returns decoded bytes plus one closing status item per string. The input
// byte is decoded in the same cycle it is accepted and its results land in a
// small result queue of QueueDepth entries, so a byte can be accepted every
// cycle while the queue holds at most QueueDepth-2 items. Each result leaves
// at one per cycle while m_axis_tready is high; a final byte that also yields
// a data byte makes two results, so the output port sets the sustained rate of
// one result per cycle. Depends on bed_pkg, bed_core and bed_outq.
`timescale 1ns / 1ps

module backslash_escape_decoder import bed_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status, [15:11] zero
  output logic        m_axis_tlast,   // end_of_string
  output logic        m_axis_tuser    // item_kind
);

  logic      fire;
  bed_push_t push;
  bed_item_t item;

  assign fire = s_axis_tvalid & s_axis_tready;

  bed_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (fire),
    .in_byte_i (s_axis_tdata),
    .in_last_i (s_axis_tlast),
    .push_o    (push)
  );

  bed_outq #(
    .Depth (QueueDepth)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (item)
  );

  assign m_axis_tdata = {5'd0, item.status, item.data};
  assign m_axis_tlast = item.eos;
  assign m_axis_tuser = item.kind;

endmodule
